// ===== rtl/gpf_pkg.sv =====
// Shared types, constants and step functions of the pairwise gravity force pipeline.
`timescale 1ns / 1ps
`default_nettype none
package gpf_pkg;

	// Register indexes of the configuration port
	localparam logic REG_GRAV = 1'b0;
	localparam logic REG_SOFT = 1'b1;

	// Front stages, magnitude quotient steps, root steps, product stages, force steps
	localparam int FRONT_STAGES = 4;
	localparam int DIV_STEPS    = 64;
	localparam int SQRT_STEPS   = 33;
	localparam int PROD_STAGES  = 2;
	localparam int FDIV_STEPS   = 32;
	localparam int LAT = FRONT_STAGES + DIV_STEPS + PROD_STAGES + FDIV_STEPS + 1;

	// One stage of the magnitude divider with the square root riding alongside
	typedef struct packed {
		logic [65:0]      rem;
		logic [65:0]      den;
		logic [63:0]      qn;
		logic             ovf;
		logic [35:0]      srem;
		logic [32:0]      root;
		logic [65:0]      srad;
		logic [2:0][32:0] mag;
		logic [2:0]       neg;
		logic             coin;
	} gpf_stage_t;

	// One stage of a force component divider
	typedef struct packed {
		logic [32:0] rem;
		logic [32:0] den;
		logic [31:0] qn;
		logic        ovf;
		logic        neg;
	} gpf_fdiv_t;

	// One restoring divide step, plus one root digit when do_sqrt is set
	function automatic gpf_stage_t gpf_step(gpf_stage_t a, logic do_sqrt);
		gpf_stage_t b;
		logic [66:0] t;
		logic [35:0] sr;
		logic [35:0] trial;
		b = a;
		t = {a.rem, a.qn[63]};
		if (t >= {1'b0, a.den}) begin
			t = t - {1'b0, a.den};
			b.qn = {a.qn[62:0], 1'b1};
		end else begin
			b.qn = {a.qn[62:0], 1'b0};
		end
		b.rem = t[65:0];
		if (do_sqrt) begin
			sr = {a.srem[33:0], a.srad[65:64]};
			trial = {1'b0, a.root, 2'b01};
			if (sr >= trial) begin
				b.srem = sr - trial;
				b.root = {a.root[31:0], 1'b1};
			end else begin
				b.srem = sr;
				b.root = {a.root[31:0], 1'b0};
			end
			b.srad = {a.srad[63:0], 2'b00};
		end
		return b;
	endfunction

	// One restoring divide step of a force component
	function automatic gpf_fdiv_t gpf_fstep(gpf_fdiv_t a);
		gpf_fdiv_t b;
		logic [33:0] t;
		b = a;
		t = {a.rem, a.qn[31]};
		if (t >= {1'b0, a.den}) begin
			t = t - {1'b0, a.den};
			b.qn = {a.qn[30:0], 1'b1};
		end else begin
			b.qn = {a.qn[30:0], 1'b0};
		end
		b.rem = t[32:0];
		return b;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/pairwise_gravity_force.sv =====
// Top level of the pairwise gravity force pipeline with output skid buffer.
`timescale 1ns / 1ps
`default_nettype none
// Takes one body pair per clock while s_tready is high and returns one force result
// per pair, in order. An accepted transaction reaches m_tdata through four input
// stages, the 64-stage quotient pipeline for G*m1*m2/(r^2+eps^2) (the 33-step square
// root runs beside it), two product stages and the 33-stage divider for each
// component. s_tready drops only once a result waits in the output register and a
// second one in the skid stage. Positions are signed Q16.16, masses and both
// registers unsigned Q16.16; each force component is rounded toward zero and
// saturated to 32 bits. When the two positions coincide the force is zero and
// m_tuser is set.
module pairwise_gravity_force
	import gpf_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic         cfg_addr,
	input  wire logic [31:0]  cfg_wdata,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// self_x, self_y, self_z, other_x, other_y, other_z, self_mass, other_mass
	input  wire logic [255:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// force_x, force_y, force_z
	output logic      [95:0]  m_tdata,
	// coincident
	output logic              m_tuser
);

	logic [31:0] grav_q;
	logic [31:0] soft_q;

	logic             en;
	logic [LAT-1:0]   vld_q;
	logic             push;

	logic [2:0][32:0] mag_s1, mag_s2, mag_s3, mag_s4;
	logic [2:0]       neg_s1, neg_s2, neg_s3, neg_s4;
	logic [63:0]      gm_s1;
	logic [31:0]      m2_s1;
	logic [2:0][65:0] sq_s2;
	logic [55:0]      plo_s2, phi_s2;
	logic [65:0]      sum_s3, sum_s4, den_s4;
	logic [63:0]      gmm_s3, gmm_s4;
	logic             coin_s4;
	logic [79:0]      gsum;

	gpf_stage_t       init;
	gpf_stage_t       main_q [0:DIV_STEPS-1];
	logic [63:0]      mg;

	logic [2:0][64:0] plo_sa, phi_sa;
	logic [32:0]      r_sa, r_sb;
	logic [2:0]       neg_sa, neg_sb;
	logic             coin_sa, coin_sb;
	logic [2:0][96:0] num_sb;
	logic [FDIV_STEPS:0] coin_q;
	logic [2:0][31:0] force_v;

	logic [95:0] res_data;
	logic        res_coin;
	logic [95:0] skid_data_q;
	logic        skid_coin_q;
	logic        skid_v_q;
	logic        out_v_q;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q <= 32'd65536;
			soft_q <= 32'd65536;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_GRAV: grav_q <= cfg_wdata;
				REG_SOFT: soft_q <= cfg_wdata;
				default:  ;
			endcase
		end
	end

	// Advance the whole pipeline unless the skid stage is full
	assign en       = !skid_v_q;
	assign s_tready = en;
	assign push     = en && vld_q[LAT-1];

	// Shift valid bits along with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	// Stage 1: separations and G*m1
	always_ff @(posedge clk) begin
		logic [32:0] d;
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d = {s_tdata[96+32*i+31], s_tdata[96+32*i +: 32]}
					- {s_tdata[32*i+31], s_tdata[32*i +: 32]};
				neg_s1[i] <= d[32];
				mag_s1[i] <= d[32] ? (33'd0 - d) : d;
			end
			gm_s1 <= 64'(grav_q) * 64'(s_tdata[223:192]);
			m2_s1 <= s_tdata[255:224];
		end
	end

	// Stage 2: squares and split mass product
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= 66'(mag_s1[i]) * 66'(mag_s1[i]);
			end
			plo_s2 <= 56'(gm_s1[39:16]) * 56'(m2_s1);
			phi_s2 <= 56'(gm_s1[63:40]) * 56'(m2_s1);
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
		end
	end

	// Stage 3: r^2 and the mass term
	assign gsum = 80'(plo_s2) + {phi_s2, 24'b0};

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			gmm_s3 <= gsum[79:16];
			mag_s3 <= mag_s2;
			neg_s3 <= neg_s2;
		end
	end

	// Stage 4: softened denominator and coincidence flag
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s4  <= sum_s3;
			den_s4  <= sum_s3 + {18'b0, soft_q, 16'b0};
			gmm_s4  <= gmm_s3;
			coin_s4 <= (sum_s3 == 66'd0);
			mag_s4  <= mag_s3;
			neg_s4  <= neg_s3;
		end
	end

	// Seed the magnitude divider and the root
	always_comb begin
		init.rem  = {34'b0, gmm_s4[63:32]};
		init.den  = den_s4;
		init.qn   = {gmm_s4[31:0], 32'b0};
		init.ovf  = ({34'b0, gmm_s4[63:32]} >= den_s4);
		init.srem = '0;
		init.root = '0;
		init.srad = sum_s4;
		init.mag  = mag_s4;
		init.neg  = neg_s4;
		init.coin = coin_s4;
	end

	// Quotient bit per stage, root digit in the first stages
	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_main
		localparam logic DoSqrt = (j < SQRT_STEPS);
		always_ff @(posedge clk) begin
			if (en) begin
				if (j == 0) begin
					main_q[j] <= gpf_step(init, DoSqrt);
				end else begin
					main_q[j] <= gpf_step(main_q[(j == 0) ? 0 : j-1], DoSqrt);
				end
			end
		end
	end

	assign mg = main_q[DIV_STEPS-1].ovf ? '1 : main_q[DIV_STEPS-1].qn;

	// Product stage A: split magnitude times separation
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				plo_sa[i] <= 65'(mg[31:0]) * 65'(main_q[DIV_STEPS-1].mag[i]);
				phi_sa[i] <= 65'(mg[63:32]) * 65'(main_q[DIV_STEPS-1].mag[i]);
			end
			r_sa    <= main_q[DIV_STEPS-1].root;
			neg_sa  <= main_q[DIV_STEPS-1].neg;
			coin_sa <= main_q[DIV_STEPS-1].coin;
		end
	end

	// Product stage B: combine partial products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				num_sb[i] <= 97'(plo_sa[i]) + {phi_sa[i], 32'b0};
			end
			r_sb    <= r_sa;
			neg_sb  <= neg_sa;
			coin_sb <= coin_sa;
		end
	end

	// Divide each component by r
	for (genvar i = 0; i < 3; i++) begin : g_fdiv
		gpf_force_div u_fdiv (
			.clk       (clk),
			.en        (en),
			.num       (num_sb[i]),
			.den       (r_sb),
			.neg       (neg_sb[i]),
			.force_val (force_v[i])
		);
	end

	// Carry the coincidence flag beside the component dividers
	always_ff @(posedge clk) begin
		if (en) begin
			coin_q <= {coin_q[FDIV_STEPS-1:0], coin_sb};
		end
	end

	assign res_coin = coin_q[FDIV_STEPS];
	assign res_data = res_coin ? 96'd0 : {force_v[2], force_v[1], force_v[0]};

	// Output register and skid stage: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (push) begin
			if (out_v_q && !m_tready) begin
				skid_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end else if (m_tready && out_v_q) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Output register and skid stage: payload
	always_ff @(posedge clk) begin
		if (push) begin
			if (out_v_q && !m_tready) begin
				skid_data_q <= res_data;
				skid_coin_q <= res_coin;
			end else begin
				m_tdata <= res_data;
				m_tuser <= res_coin;
			end
		end else if (m_tready && out_v_q && skid_v_q) begin
			m_tdata <= skid_data_q;
			m_tuser <= skid_coin_q;
		end
	end

	assign m_tvalid = out_v_q;

endmodule
`default_nettype wire

// ===== rtl/gpf_force_div.sv =====
// Pipelined divider for one force component, with sign and 32-bit saturation.
`timescale 1ns / 1ps
`default_nettype none
module gpf_force_div
	import gpf_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [96:0] num,
	input  wire logic [32:0] den,
	input  wire logic        neg,
	output logic      [31:0] force_val
);

	gpf_fdiv_t   st_q [0:FDIV_STEPS];
	logic [31:0] lim;
	logic [31:0] mag_v;

	// Flag quotients of 2^32 and up, seed remainder with the high part
	always_ff @(posedge clk) begin
		if (en) begin
			st_q[0].ovf <= (num[96:32] >= {32'b0, den});
			st_q[0].rem <= num[64:32];
			st_q[0].qn  <= num[31:0];
			st_q[0].den <= den;
			st_q[0].neg <= neg;
		end
	end

	// One quotient bit per stage
	for (genvar k = 1; k <= FDIV_STEPS; k++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				st_q[k] <= gpf_fstep(st_q[k-1]);
			end
		end
	end

	// Saturate toward the signed limit, then apply the sign
	always_comb begin
		lim = st_q[FDIV_STEPS].neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
		mag_v = (st_q[FDIV_STEPS].ovf || st_q[FDIV_STEPS].qn > lim) ? lim
			: st_q[FDIV_STEPS].qn;
		force_val = st_q[FDIV_STEPS].neg ? (32'd0 - mag_v) : mag_v;
	end

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the pairwise gravity force pipeline.
`timescale 1ns / 1ps

typedef struct {
	logic [31:0] fx;
	logic [31:0] fy;
	logic [31:0] fz;
	logic        coin;
} force_t;

class force_scoreboard;
	logic [31:0] grav;
	logic [31:0] soft_sq;
	force_t      pending[$];
	int          errors;

	function new();
		grav = 32'd65536;
		soft_sq = 32'd65536;
		errors = 0;
	endfunction

	// Compute the expected force for one body pair
	function force_t predict_force(logic [255:0] d);
		force_t      f;
		logic [32:0] mag[3];
		logic        neg[3];
		logic [32:0] dd;
		logic [127:0] sq, den, root, cand, prod, gmm, quo, t, lim, v;
		logic [63:0] mg;
		logic [31:0] comp[3];
		sq = 0;
		for (int i = 0; i < 3; i++) begin
			dd = {d[32*(i+3)+31], d[32*(i+3) +: 32]} - {d[32*i+31], d[32*i +: 32]};
			neg[i] = dd[32];
			mag[i] = neg[i] ? -dd : dd;
			sq = sq + 128'(mag[i]) * 128'(mag[i]);
		end
		if (sq == 0) begin
			f.fx = 0; f.fy = 0; f.fz = 0; f.coin = 1'b1;
			return f;
		end
		// floor of the square root, one bit at a time
		root = 0;
		for (int b = 63; b >= 0; b--) begin
			cand = root | (128'd1 << b);
			if (cand * cand <= sq) root = cand;
		end
		den = sq + (128'(soft_sq) << 16);
		prod = (128'(grav) * 128'(d[223:192])) >> 16;
		gmm = ((prod * 128'(d[255:224])) >> 16) & {64'd0, {64{1'b1}}};
		quo = (gmm << 32) / den;
		mg = (quo[127:64] != 0) ? {64{1'b1}} : quo[63:0];
		for (int i = 0; i < 3; i++) begin
			t = (128'(mg) * 128'(mag[i])) / root;
			lim = neg[i] ? 128'h8000_0000 : 128'h7FFF_FFFF;
			v = (t > lim) ? lim : t;
			comp[i] = neg[i] ? (32'd0 - v[31:0]) : v[31:0];
		end
		f.fx = comp[0]; f.fy = comp[1]; f.fz = comp[2]; f.coin = 1'b0;
		return f;
	endfunction

	function void note_pair(logic [255:0] d);
		pending.push_back(predict_force(d));
	endfunction

	function void check_force(logic [95:0] data, logic coin);
		force_t e;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result %h coin %b", $time, data, coin);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (data[31:0] !== e.fx) begin
			$display("%0t: force_x expected %h actual %h", $time, e.fx, data[31:0]);
			errors++;
		end
		if (data[63:32] !== e.fy) begin
			$display("%0t: force_y expected %h actual %h", $time, e.fy, data[63:32]);
			errors++;
		end
		if (data[95:64] !== e.fz) begin
			$display("%0t: force_z expected %h actual %h", $time, e.fz, data[95:64]);
			errors++;
		end
		if (coin !== e.coin) begin
			$display("%0t: coincident expected %b actual %b", $time, e.coin, coin);
			errors++;
		end
	endfunction
endclass

module tb_top;
	import gpf_pkg::*;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic         cfg_addr = 1'b0;
	logic [31:0]  cfg_wdata = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [255:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [95:0]  m_tdata;
	logic         m_tuser;

	force_scoreboard sb = new();
	bit quiet = 0;
	bit hold_req = 0;

	pairwise_gravity_force dut (.*);

	always #5 clk = ~clk;

	// Abort a hung run
	initial begin
		#3ms;
		$display("tb: failure");
		$finish;
	end

	// Check results and toggle backpressure in bursts
	initial begin
		int run;
		run = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) sb.check_force(m_tdata, m_tuser);
			@(negedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (400) @(negedge clk);
				hold_req = 0;
				m_tready <= 1'b1;
			end else if (quiet) begin
				m_tready <= 1'b1;
			end else if (run > 0) begin
				run--;
				if (run == 0) m_tready <= 1'b1;
			end else if ($urandom_range(0, 4) == 0) begin
				run = $urandom_range(1, 5);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic write_reg(logic addr, logic [31:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (addr == REG_GRAV) sb.grav = value;
		else sb.soft_sq = value;
	endtask

	// Offer one pair and hold it until the transaction completes
	task automatic send_pair(logic [255:0] d);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
		sb.note_pair(d);
		@(negedge clk);
	endtask

	// Drop valid right away, then wait for every result to come back
	task automatic drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (LAT + 10) @(negedge clk);
	endtask

	function automatic logic [255:0] pack_pair(logic [31:0] sx, sy, sz, ox, oy, oz, m1, m2);
		return {m2, m1, oz, oy, ox, sz, sy, sx};
	endfunction

	// Mix of full-range, nearby, coincident and single-axis pairs
	function automatic logic [255:0] random_pair();
		logic [31:0] p[6];
		logic [31:0] m1, m2;
		int mode;
		mode = $urandom_range(0, 9);
		for (int i = 0; i < 6; i++) p[i] = $urandom;
		if (mode >= 3 && mode <= 6) begin
			for (int i = 0; i < 3; i++)
				p[i+3] = p[i] + $signed($urandom_range(0, 1 << $urandom_range(0, 22))) *
					($urandom_range(0, 1) ? 1 : -1);
		end else if (mode == 7) begin
			for (int i = 0; i < 3; i++) p[i+3] = p[i];
		end else if (mode == 8) begin
			p[3] = p[0]; p[4] = p[1];
		end
		m1 = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 20);
		m2 = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 20);
		return pack_pair(p[0], p[1], p[2], p[3], p[4], p[5], m1, m2);
	endfunction

	task automatic run_random(int n);
		repeat (n) send_pair(random_pair());
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Directed: extremes, coincidence, zero and full masses
		send_pair(pack_pair(0, 0, 0, 0, 0, 0, 32'h10000, 32'h10000));
		send_pair(pack_pair(32'h1234, 32'h1234, 32'h1234, 32'h1234, 32'h1234, 32'h1234,
			'1, '1));
		send_pair(pack_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1, '1));
		send_pair(pack_pair(32'h7FFF_FFFF, 32'h8000_0000, 0,
			32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h10000, 32'h10000));
		send_pair(pack_pair(0, 0, 0, 1, 0, 0, '1, '1));
		send_pair(pack_pair(0, 0, 0, 0, 32'hFFFF_FFFF, 0, '1, '1));
		send_pair(pack_pair(0, 0, 0, 0, 0, 32'h10000, 0, '1));
		send_pair(pack_pair(0, 0, 0, 32'h10000, 32'h10000, 32'h10000, '1, 0));
		send_pair(pack_pair(5, 6, 7, 32'hFFFF_0000, 32'h20000, 32'h30000, 32'h10000, 32'h20000));
		drain();
		run_random(200);
		drain();

		// Zero softening, maximum constant: huge magnitudes saturate
		write_reg(REG_SOFT, 0);
		write_reg(REG_GRAV, '1);
		send_pair(pack_pair(0, 0, 0, 1, 1, 1, '1, '1));
		send_pair(pack_pair(0, 0, 0, 0, 0, 0, '1, '1));
		send_pair(pack_pair(0, 0, 0, 32'hFFFF_FFFF, 0, 0, 32'h10000, 32'h10000));
		hold_req = 1;
		run_random(250);
		drain();

		// Zero constant, maximum softening
		write_reg(REG_GRAV, 0);
		write_reg(REG_SOFT, '1);
		run_random(100);
		drain();

		write_reg(REG_GRAV, 32'h10000);
		run_random(150);
		drain();

		// Random settings
		repeat (3) begin
			write_reg(REG_GRAV, $urandom);
			write_reg(REG_SOFT, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 16));
			run_random(100);
			drain();
		end

		// Last stretch without idling on either side
		quiet = 1;
		write_reg(REG_GRAV, 32'h10000);
		write_reg(REG_SOFT, 32'h100);
		run_random(130);
		drain();

		if (sb.errors == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/gpf_pkg.sv
rtl/gpf_force_div.sv
rtl/pairwise_gravity_force.sv
tb/tb_top.sv
